// ===== src/assert_macros.svh =====
// assertion helpers for the linked list manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/alm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alm_pkg
// shared types and codes for the array linked list manager
// ---------------------------------------------------------------------------
package alm_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int DATA_BITS_DEF = 8;

	localparam logic [2:0] OP_INSERT_AT = 3'd0;
	localparam logic [2:0] OP_INSERT_AFTER = 3'd1;
	localparam logic [2:0] OP_INSERT_BEFORE = 3'd2;
	localparam logic [2:0] OP_REMOVE_SLOT = 3'd3;
	localparam logic [2:0] OP_REMOVE_AT = 3'd4;
	localparam logic [2:0] OP_GET_AT = 3'd5;
	localparam logic [2:0] OP_READ_SLOT = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL_EMPTY = 2'd2;
	localparam logic [1:0] ST_BAD_SLOT = 2'd3;

	// sequencer states
	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_WALK_WAIT,
		S_PREP,
		S_RD,
		S_RD_WAIT,
		S_WR,
		S_OUT
	} state_t;

	// memory write enables from the sequencer to the link store
	typedef struct packed {
		logic nxt_we;
		logic prv_we;
		logic dat_we;
	} mem_we_t;

endpackage

// ===== src/array_linked_list_manager.sv =====
`timescale 1ns / 1ps
// position lookups walk from the nearer end, at most SLOTS/2 - 1 links
// one word in flight: a new word is taken the cycle after the result is accepted,
// so the pace per word is set by the link walk and the three registered reads
// through the single memory read port
// after reset a pass over all slots rebuilds the free chain, no input taken
// ---------------------------------------------------------------------------
// array_linked_list_manager
// doubly linked list in a slot array with the free chain behind the tail
// ---------------------------------------------------------------------------
module array_linked_list_manager #(
	parameter int SLOTS = alm_pkg::SLOTS_DEF,
	parameter int DATA_BITS = alm_pkg::DATA_BITS_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int LW = $clog2(SLOTS + 1),
	localparam int IW = 3 + LW + SW + DATA_BITS,
	localparam int OW = 2 + SW + DATA_BITS + 3 * LW,
	localparam int IB = ((IW + 7) / 8) * 8,
	localparam int OB = ((OW + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// op, position, slot, data_in
	input  logic [IB-1:0] s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status, result_slot, data_out, prev_slot, next_slot, entries
	output logic [OB-1:0] m_tdata
);

	localparam logic [LW-1:0] NONE = LW'(SLOTS);

	// operation plan codes
	localparam logic [2:0] K_FIRST = 3'd0;
	localparam logic [2:0] K_FRONT = 3'd1;
	localparam logic [2:0] K_BACK = 3'd2;
	localparam logic [2:0] K_BEFORE = 3'd3;
	localparam logic [2:0] K_AFTER = 3'd4;
	localparam logic [2:0] K_DROP = 3'd5;
	localparam logic [2:0] K_REPORT = 3'd6;
	localparam logic [2:0] K_NONE = 3'd7;

	alm_pkg::state_t state_q, state_d;

	// request fields
	logic [2:0] op_q;
	logic [LW-1:0] pos_q;
	logic [SW-1:0] ref_q;
	logic [DATA_BITS-1:0] din_q;

	// list registers
	logic [SW-1:0] head_q, tail_q;
	logic [LW-1:0] count_q;
	logic [SLOTS-1:0] in_use_q;
	logic [SW-1:0] init_q;

	// walk and operation context
	logic [SW-1:0] cur_q;
	logic [LW-1:0] steps_q;
	logic dir_back_q;
	logic [SW-1:0] tgt_q;
	logic [2:0] rd_idx_q;
	logic [LW-1:0] t_nxt_q, t_prv_q, tl_nxt_q, f_nxt_q;
	logic [DATA_BITS-1:0] t_dat_q;
	logic [2:0] wr_idx_q;

	// result
	logic [1:0] st_q;
	logic [SW-1:0] rs_q;
	logic [DATA_BITS-1:0] rd_q;
	logic [LW-1:0] rp_q, rn_q;

	// memory wiring
	alm_pkg::mem_we_t we;
	logic [SW-1:0] nxt_wa, prv_wa, dat_wa, raddr;
	logic [LW-1:0] nxt_wd, prv_wd;
	logic [LW-1:0] nxt_rd, prv_rd;
	logic [DATA_BITS-1:0] dat_rd;

	alm_link_mem #(.SLOTS(SLOTS), .DATA_BITS(DATA_BITS)) u_mem (
		.clk(clk), .we(we),
		.nxt_waddr(nxt_wa), .nxt_wdata(nxt_wd),
		.prv_waddr(prv_wa), .prv_wdata(prv_wd),
		.dat_waddr(dat_wa), .dat_wdata(din_q),
		.raddr(raddr), .nxt_rdata(nxt_rd), .prv_rdata(prv_rd), .dat_rdata(dat_rd)
	);

	// input field slices
	logic [2:0] in_op;
	logic [LW-1:0] in_pos;
	logic [SW-1:0] in_slot;
	logic [DATA_BITS-1:0] in_din;
	assign in_op = s_tdata[2:0];
	assign in_pos = s_tdata[3 +: LW];
	assign in_slot = s_tdata[3 + LW +: SW];
	assign in_din = s_tdata[3 + LW + SW +: DATA_BITS];

	assign s_tready = (state_q == alm_pkg::S_IDLE);
	assign m_tvalid = (state_q == alm_pkg::S_OUT);
	assign m_tdata = OB'({count_q, rn_q, rp_q, rd_q, rs_q, st_q});

	logic ref_ok;
	assign ref_ok = in_use_q[ref_q];

	// operation plan decoded in the check state
	logic [2:0] kind_q;
	logic is_ins;
	assign is_ins = (op_q == alm_pkg::OP_INSERT_AT) || (op_q == alm_pkg::OP_INSERT_AFTER)
		|| (op_q == alm_pkg::OP_INSERT_BEFORE);

	// read addresses for gathering: 0 target, 1 tail, 2 free slot
	logic [SW-1:0] nb_s;
	// free slot is next of tail
	logic [SW-1:0] fs;
	assign fs = tl_nxt_q[SW-1:0];

	// write plan and next state: computed combinationally per state and write index
	always_comb begin
		we = '0;
		nxt_wa = '0; nxt_wd = '0;
		prv_wa = '0; prv_wd = '0;
		dat_wa = '0;
		raddr = cur_q;
		nb_s = '0;
		state_d = state_q;
		case (state_q)
			alm_pkg::S_INIT: begin
				we.nxt_we = 1'b1; nxt_wa = init_q; nxt_wd = LW'(init_q) + LW'(1);
				we.prv_we = 1'b1; prv_wa = init_q; prv_wd = NONE;
				if (init_q == SW'(SLOTS - 1)) state_d = alm_pkg::S_IDLE;
			end
			alm_pkg::S_IDLE: if (s_tvalid) state_d = alm_pkg::S_CHECK;
			alm_pkg::S_CHECK: state_d = alm_pkg::S_PREP;
			alm_pkg::S_WALK: begin
				raddr = cur_q;
				state_d = alm_pkg::S_WALK_WAIT;
			end
			alm_pkg::S_WALK_WAIT: begin
				state_d = (steps_q == LW'(1)) ? alm_pkg::S_RD : alm_pkg::S_WALK;
			end
			alm_pkg::S_PREP: state_d = (steps_q != '0) ? alm_pkg::S_WALK : alm_pkg::S_RD;
			alm_pkg::S_RD: begin
				case (rd_idx_q)
					3'd0: raddr = tgt_q;
					3'd1: raddr = tail_q;
					default: raddr = fs;
				endcase
				state_d = alm_pkg::S_RD_WAIT;
			end
			alm_pkg::S_RD_WAIT: begin
				state_d = (rd_idx_q == 3'd2) ? alm_pkg::S_WR : alm_pkg::S_RD;
			end
			alm_pkg::S_WR: begin
				// sequence of link writes, at most one per memory per cycle
				case (kind_q)
					K_FIRST: begin // first entry at head
						we.prv_we = 1'b1; prv_wa = head_q; prv_wd = NONE;
						we.dat_we = 1'b1; dat_wa = head_q;
					end
					K_FRONT: begin // new head before head
						if (wr_idx_q == 3'd0) begin
							we.nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = f_nxt_q;
							we.prv_we = 1'b1; prv_wa = head_q; prv_wd = LW'(fs);
						end else begin
							we.nxt_we = 1'b1; nxt_wa = fs; nxt_wd = LW'(head_q);
							we.prv_we = 1'b1; prv_wa = fs; prv_wd = NONE;
							we.dat_we = 1'b1; dat_wa = fs;
						end
					end
					K_BACK: begin // append behind tail
						we.prv_we = 1'b1; prv_wa = fs; prv_wd = LW'(tail_q);
						we.dat_we = 1'b1; dat_wa = fs;
					end
					K_BEFORE: begin // before tgt, tgt not head
						nb_s = t_prv_q[SW-1:0];
						case (wr_idx_q)
							3'd0: begin
								we.nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = f_nxt_q;
								we.prv_we = 1'b1; prv_wa = fs; prv_wd = t_prv_q;
							end
							3'd1: begin
								we.nxt_we = 1'b1; nxt_wa = fs; nxt_wd = LW'(tgt_q);
								we.prv_we = 1'b1; prv_wa = tgt_q; prv_wd = LW'(fs);
							end
							default: begin
								we.nxt_we = 1'b1; nxt_wa = nb_s; nxt_wd = LW'(fs);
								we.dat_we = 1'b1; dat_wa = fs;
							end
						endcase
					end
					K_AFTER: begin // after tgt, tgt not tail
						nb_s = t_nxt_q[SW-1:0];
						case (wr_idx_q)
							3'd0: begin
								we.nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = f_nxt_q;
								we.prv_we = 1'b1; prv_wa = nb_s; prv_wd = LW'(fs);
							end
							3'd1: begin
								we.nxt_we = 1'b1; nxt_wa = fs; nxt_wd = t_nxt_q;
								we.prv_we = 1'b1; prv_wa = fs; prv_wd = LW'(tgt_q);
							end
							default: begin
								we.nxt_we = 1'b1; nxt_wa = tgt_q; nxt_wd = LW'(fs);
								we.dat_we = 1'b1; dat_wa = fs;
							end
						endcase
					end
					K_DROP: begin // drop tgt
						if (tgt_q == head_q) begin
							if (count_q > LW'(1)) begin
								case (wr_idx_q)
									3'd0: begin
										we.prv_we = 1'b1; prv_wa = t_nxt_q[SW-1:0]; prv_wd = NONE;
										we.nxt_we = 1'b1; nxt_wa = tgt_q; nxt_wd = tl_nxt_q;
									end
									3'd1: begin
										we.nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = LW'(tgt_q);
									end
									default: begin
										we.prv_we = 1'b1; prv_wa = tgt_q; prv_wd = NONE;
									end
								endcase
							end else if (wr_idx_q == 3'd2) begin
								we.prv_we = 1'b1; prv_wa = tgt_q; prv_wd = NONE;
							end
						end else if (tgt_q == tail_q) begin
							if (wr_idx_q == 3'd2) begin
								we.prv_we = 1'b1; prv_wa = tgt_q; prv_wd = NONE;
							end
						end else begin
							case (wr_idx_q)
								3'd0: begin
									we.nxt_we = 1'b1; nxt_wa = t_prv_q[SW-1:0]; nxt_wd = t_nxt_q;
									we.prv_we = 1'b1; prv_wa = t_nxt_q[SW-1:0]; prv_wd = t_prv_q;
								end
								3'd1: begin
									we.nxt_we = 1'b1; nxt_wa = tgt_q; nxt_wd = tl_nxt_q;
								end
								default: begin
									we.nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = LW'(tgt_q);
									we.prv_we = 1'b1; prv_wa = tgt_q; prv_wd = NONE;
								end
							endcase
						end
					end
					default: ;
				endcase
				if (wr_idx_q == 3'd2 || kind_q == K_FIRST || kind_q == K_BACK
					|| kind_q == K_REPORT || (kind_q == K_FRONT && wr_idx_q == 3'd1))
					state_d = alm_pkg::S_OUT;
			end
			alm_pkg::S_OUT: if (m_tready) state_d = alm_pkg::S_IDLE;
			default: state_d = alm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alm_pkg::S_INIT;
			init_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			in_use_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == alm_pkg::S_INIT) init_q <= init_q + SW'(1);
			// list register updates at the end of the write sequence
			if (state_q == alm_pkg::S_WR && state_d == alm_pkg::S_OUT) begin
				case (kind_q)
					K_FIRST: begin
						tail_q <= head_q; in_use_q[head_q] <= 1'b1; count_q <= count_q + LW'(1);
					end
					K_FRONT: begin
						head_q <= fs; in_use_q[fs] <= 1'b1; count_q <= count_q + LW'(1);
					end
					K_BACK: begin
						tail_q <= fs; in_use_q[fs] <= 1'b1; count_q <= count_q + LW'(1);
					end
					K_BEFORE, K_AFTER: begin
						in_use_q[fs] <= 1'b1; count_q <= count_q + LW'(1);
					end
					K_DROP: begin
						if (tgt_q == head_q) begin
							if (count_q > LW'(1)) head_q <= t_nxt_q[SW-1:0];
						end else if (tgt_q == tail_q) begin
							tail_q <= t_prv_q[SW-1:0];
						end
						in_use_q[tgt_q] <= 1'b0;
						count_q <= count_q - LW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			alm_pkg::S_IDLE: begin
				op_q <= in_op; pos_q <= in_pos; ref_q <= in_slot; din_q <= in_din;
			end
			alm_pkg::S_CHECK: begin
				st_q <= alm_pkg::ST_OK;
				rs_q <= '0; rd_q <= '0; rp_q <= NONE; rn_q <= NONE;
				kind_q <= K_NONE;
				tgt_q <= ref_q;
				steps_q <= '0;
				if (op_q == alm_pkg::OP_INSERT_AT && pos_q > count_q) st_q <= alm_pkg::ST_RANGE;
				else if (is_ins && op_q != alm_pkg::OP_INSERT_AT && !ref_ok)
					st_q <= alm_pkg::ST_BAD_SLOT;
				else if (is_ins && count_q >= LW'(SLOTS)) st_q <= alm_pkg::ST_FULL_EMPTY;
				else if (is_ins) begin
					if (count_q == '0) kind_q <= K_FIRST;
					else if (op_q == alm_pkg::OP_INSERT_AFTER)
						kind_q <= (ref_q == tail_q) ? K_BACK : K_AFTER;
					else if (op_q == alm_pkg::OP_INSERT_BEFORE)
						kind_q <= (ref_q == head_q) ? K_FRONT : K_BEFORE;
					else if (pos_q == '0) kind_q <= K_FRONT;
					else if (pos_q == count_q) kind_q <= K_BACK;
					else begin
						kind_q <= K_BEFORE;
						// walk from the nearer end
						if (pos_q < (count_q >> 1)) begin
							dir_back_q <= 1'b0; cur_q <= head_q; tgt_q <= head_q;
							steps_q <= pos_q;
						end else begin
							dir_back_q <= 1'b1; cur_q <= tail_q; tgt_q <= tail_q;
							steps_q <= count_q - pos_q - LW'(1);
						end
					end
				end else if (op_q == alm_pkg::OP_REMOVE_SLOT || op_q == alm_pkg::OP_READ_SLOT) begin
					if (!ref_ok) st_q <= alm_pkg::ST_BAD_SLOT;
					else kind_q <= (op_q == alm_pkg::OP_REMOVE_SLOT) ? K_DROP : K_REPORT;
				end else if (op_q == alm_pkg::OP_REMOVE_AT || op_q == alm_pkg::OP_GET_AT) begin
					if (count_q == '0) st_q <= alm_pkg::ST_FULL_EMPTY;
					else if (pos_q >= count_q) st_q <= alm_pkg::ST_RANGE;
					else begin
						kind_q <= (op_q == alm_pkg::OP_REMOVE_AT) ? K_DROP : K_REPORT;
						if (pos_q < (count_q >> 1)) begin
							dir_back_q <= 1'b0; cur_q <= head_q; tgt_q <= head_q;
							steps_q <= pos_q;
						end else begin
							dir_back_q <= 1'b1; cur_q <= tail_q; tgt_q <= tail_q;
							steps_q <= count_q - pos_q - LW'(1);
						end
					end
				end else st_q <= alm_pkg::ST_RANGE;
			end
			alm_pkg::S_WALK_WAIT: begin
				cur_q <= dir_back_q ? prv_rd[SW-1:0] : nxt_rd[SW-1:0];
				tgt_q <= dir_back_q ? prv_rd[SW-1:0] : nxt_rd[SW-1:0];
				steps_q <= steps_q - LW'(1);
			end
			alm_pkg::S_PREP: begin
				rd_idx_q <= 3'd0; wr_idx_q <= 3'd0;
			end
			alm_pkg::S_RD_WAIT: begin
				case (rd_idx_q)
					3'd0: begin t_nxt_q <= nxt_rd; t_prv_q <= prv_rd; t_dat_q <= dat_rd; end
					3'd1: tl_nxt_q <= nxt_rd;
					default: f_nxt_q <= nxt_rd;
				endcase
				rd_idx_q <= rd_idx_q + 3'd1;
			end
			alm_pkg::S_WR: begin
				wr_idx_q <= wr_idx_q + 3'd1;
				if (state_d == alm_pkg::S_OUT && st_q == alm_pkg::ST_OK) begin
					case (kind_q)
						K_FIRST: begin rs_q <= head_q; rd_q <= din_q; rp_q <= NONE; rn_q <= NONE; end
						K_FRONT: begin
							rs_q <= fs; rd_q <= din_q; rp_q <= NONE; rn_q <= LW'(head_q);
						end
						K_BACK: begin
							rs_q <= fs; rd_q <= din_q; rp_q <= LW'(tail_q); rn_q <= NONE;
						end
						K_BEFORE: begin
							rs_q <= fs; rd_q <= din_q; rp_q <= t_prv_q; rn_q <= LW'(tgt_q);
						end
						K_AFTER: begin
							rs_q <= fs; rd_q <= din_q; rp_q <= LW'(tgt_q); rn_q <= t_nxt_q;
						end
						K_DROP, K_REPORT: begin
							rs_q <= tgt_q; rd_q <= t_dat_q; rp_q <= t_prv_q;
							rn_q <= (tgt_q == tail_q) ? NONE : t_nxt_q;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_ready_out_excl, clk, arst_n, s_tready, !m_tvalid, "ready while result pending")
	`ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= LW'(SLOTS), "count beyond slots")
	`ASSERT_NEXT(a_accept_check, clk, arst_n, s_tvalid && s_tready, state_q == alm_pkg::S_CHECK, "no check")

endmodule

// ===== src/alm_link_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alm_link_mem
// link and payload store, one write port and one registered read port each
// ---------------------------------------------------------------------------
module alm_link_mem #(
	parameter int SLOTS = alm_pkg::SLOTS_DEF,
	parameter int DATA_BITS = alm_pkg::DATA_BITS_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int LW = $clog2(SLOTS + 1)
) (
	input  logic                 clk,
	input  alm_pkg::mem_we_t     we,
	input  logic [SW-1:0]        nxt_waddr,
	input  logic [LW-1:0]        nxt_wdata,
	input  logic [SW-1:0]        prv_waddr,
	input  logic [LW-1:0]        prv_wdata,
	input  logic [SW-1:0]        dat_waddr,
	input  logic [DATA_BITS-1:0] dat_wdata,
	input  logic [SW-1:0]        raddr,
	output logic [LW-1:0]        nxt_rdata,
	output logic [LW-1:0]        prv_rdata,
	output logic [DATA_BITS-1:0] dat_rdata
);

	logic [LW-1:0] nxt_mem [SLOTS];
	logic [LW-1:0] prv_mem [SLOTS];
	logic [DATA_BITS-1:0] dat_mem [SLOTS];

	// next links
	always_ff @(posedge clk) begin
		if (we.nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
		nxt_rdata <= nxt_mem[raddr];
	end

	// previous links
	always_ff @(posedge clk) begin
		if (we.prv_we) prv_mem[prv_waddr] <= prv_wdata;
		prv_rdata <= prv_mem[raddr];
	end

	// payload
	always_ff @(posedge clk) begin
		if (we.dat_we) dat_mem[dat_waddr] <= dat_wdata;
		dat_rdata <= dat_mem[raddr];
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives list requests into the array linked list manager, predicts each
// result word with a behavioral copy of the list, and compares the whole word
// ---------------------------------------------------------------------------
module testbench;

	localparam int NSLOT = 64;
	localparam logic [6:0] NONE = 7'd64;
	localparam logic [2:0] OP_UNDEF = 3'd7;
	localparam int IBW = 24;
	localparam int OBW = 40;
	localparam int WATCH_LIMIT = 20000;

	// fields from the highest bit down, op in the lowest bits
	typedef struct packed {
		logic [7:0] data_in;
		logic [5:0] slot;
		logic [6:0] position;
		logic [2:0] op;
	} request_t;

	// fields from the highest bit down, status in the lowest bits
	typedef struct packed {
		logic [6:0] entries;
		logic [6:0] next_slot;
		logic [6:0] prev_slot;
		logic [7:0] data_out;
		logic [5:0] result_slot;
		logic [1:0] status;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IBW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OBW-1:0] m_tdata;

	array_linked_list_manager u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// shadow list state
	logic [6:0] lnk_next [NSLOT];
	logic [6:0] lnk_prev [NSLOT];
	logic [7:0] payload [NSLOT];
	bit used [NSLOT];
	logic [6:0] head_q, tail_q, count_q;

	request_t pending_reqs[$];
	reply_t replies_due[$];
	int errors = 0;
	bit stim_done = 0;
	int hold_off = 0;

	function automatic logic [6:0] nx(logic [6:0] s);
		return s < NSLOT ? lnk_next[s] : NONE;
	endfunction
	function automatic logic [6:0] pv(logic [6:0] s);
		return s < NSLOT ? lnk_prev[s] : NONE;
	endfunction
	function automatic void set_nx(logic [6:0] s, logic [6:0] v);
		if (s < NSLOT) lnk_next[s] = v;
	endfunction
	function automatic void set_pv(logic [6:0] s, logic [6:0] v);
		if (s < NSLOT) lnk_prev[s] = v;
	endfunction
	function automatic logic [6:0] list_nx(logic [6:0] s);
		return s == tail_q ? NONE : nx(s);
	endfunction

	function automatic logic [6:0] walk_to(logic [6:0] pos);
		logic [6:0] s;
		if (pos < count_q / 2) begin
			s = head_q;
			for (int i = 0; i < pos; i++) s = nx(s);
		end else begin
			s = tail_q;
			for (int i = 0; i + 1 + pos < count_q; i++) s = pv(s);
		end
		return s;
	endfunction

	function automatic logic [6:0] take_free();
		logic [6:0] f;
		f = nx(tail_q);
		set_nx(tail_q, nx(f));
		return f;
	endfunction

	function automatic logic [6:0] link_front();
		logic [6:0] f;
		f = take_free();
		set_nx(f, head_q);
		set_pv(head_q, f);
		set_pv(f, NONE);
		head_q = f;
		return f;
	endfunction

	function automatic logic [6:0] link_before(logic [6:0] t);
		logic [6:0] f, p;
		if (t == head_q) return link_front();
		f = take_free();
		p = pv(t);
		set_pv(f, p);
		set_nx(f, t);
		set_nx(p, f);
		set_pv(t, f);
		return f;
	endfunction

	function automatic logic [6:0] link_after(logic [6:0] r);
		logic [6:0] f, n;
		if (r == tail_q) begin
			f = nx(tail_q);
			set_pv(f, tail_q);
			tail_q = f;
			return f;
		end
		f = take_free();
		n = nx(r);
		set_nx(f, n);
		set_pv(n, f);
		set_nx(r, f);
		set_pv(f, r);
		return f;
	endfunction

	function automatic void unlink(logic [6:0] s);
		logic [6:0] p, n;
		p = pv(s);
		n = nx(s);
		if (s == head_q) begin
			if (count_q > 1) begin
				head_q = n;
				set_pv(n, NONE);
				set_nx(s, nx(tail_q));
				set_nx(tail_q, s);
			end
		end else if (s == tail_q) begin
			tail_q = p;
		end else begin
			set_nx(p, n);
			set_pv(n, p);
			set_nx(s, nx(tail_q));
			set_nx(tail_q, s);
		end
		set_pv(s, NONE);
		used[s[5:0]] = 0;
		count_q--;
	endfunction

	function automatic void list_clear();
		for (int i = 0; i < NSLOT; i++) begin
			lnk_next[i] = 7'(i + 1);
			lnk_prev[i] = NONE;
			payload[i] = '0;
			used[i] = 0;
		end
		head_q = 0;
		tail_q = 0;
		count_q = 0;
	endfunction

	// apply one request to the shadow list and return the expected reply
	function automatic reply_t list_apply(request_t r);
		reply_t y;
		logic [6:0] s, p, n;
		bit ref_ok;
		logic [1:0] st;
		ref_ok = used[r.slot];
		st = alm_pkg::ST_OK;
		s = 0;
		p = NONE;
		n = NONE;
		case (r.op)
			alm_pkg::OP_INSERT_AT, alm_pkg::OP_INSERT_AFTER, alm_pkg::OP_INSERT_BEFORE: begin
				if (r.op == alm_pkg::OP_INSERT_AT && r.position > count_q)
					st = alm_pkg::ST_RANGE;
				else if (r.op != alm_pkg::OP_INSERT_AT && !ref_ok) st = alm_pkg::ST_BAD_SLOT;
				else if (count_q >= NSLOT) st = alm_pkg::ST_FULL_EMPTY;
				else begin
					if (count_q == 0) begin
						s = head_q;
						tail_q = s;
						set_pv(s, NONE);
					end else if (r.op == alm_pkg::OP_INSERT_AFTER) s = link_after(7'(r.slot));
					else if (r.op == alm_pkg::OP_INSERT_BEFORE) s = link_before(7'(r.slot));
					else if (r.position == 0) s = link_front();
					else if (r.position == count_q) s = link_after(tail_q);
					else s = link_before(walk_to(r.position));
					payload[s[5:0]] = r.data_in;
					used[s[5:0]] = 1;
					count_q++;
					p = pv(s);
					n = list_nx(s);
				end
			end
			alm_pkg::OP_REMOVE_SLOT, alm_pkg::OP_REMOVE_AT: begin
				if (r.op == alm_pkg::OP_REMOVE_SLOT && !ref_ok) st = alm_pkg::ST_BAD_SLOT;
				else if (r.op == alm_pkg::OP_REMOVE_AT && count_q == 0)
					st = alm_pkg::ST_FULL_EMPTY;
				else if (r.op == alm_pkg::OP_REMOVE_AT && r.position >= count_q)
					st = alm_pkg::ST_RANGE;
				else begin
					s = (r.op == alm_pkg::OP_REMOVE_SLOT) ? 7'(r.slot) : walk_to(r.position);
					p = pv(s);
					n = list_nx(s);
					unlink(s);
				end
			end
			alm_pkg::OP_GET_AT: begin
				if (count_q == 0) st = alm_pkg::ST_FULL_EMPTY;
				else if (r.position >= count_q) st = alm_pkg::ST_RANGE;
				else begin
					s = walk_to(r.position);
					p = pv(s);
					n = list_nx(s);
				end
			end
			alm_pkg::OP_READ_SLOT: begin
				if (!ref_ok) st = alm_pkg::ST_BAD_SLOT;
				else begin
					s = 7'(r.slot);
					p = pv(s);
					n = list_nx(s);
				end
			end
			default: st = alm_pkg::ST_RANGE;
		endcase
		y.status = st;
		y.result_slot = (st == alm_pkg::ST_OK) ? s[5:0] : '0;
		y.data_out = (st == alm_pkg::ST_OK) ? payload[s[5:0]] : '0;
		y.prev_slot = p;
		y.next_slot = n;
		y.entries = count_q;
		return y;
	endfunction

	function automatic request_t mk(logic [2:0] op, int pos, int sl, int d);
		request_t r;
		r.op = op;
		r.position = 7'(pos);
		r.slot = 6'(sl);
		r.data_in = 8'(d);
		return r;
	endfunction

	// pick a slot that is in use most of the time, else anything
	function automatic int pick_slot();
		int c;
		for (int k = 0; k < 8; k++) begin
			c = $urandom_range(0, NSLOT - 1);
			if (used[c]) return c;
		end
		return $urandom_range(0, NSLOT - 1);
	endfunction

	// stimulus: directed, then random; a scratch copy of the list steers slots
	initial begin
		int n;
		request_t r;
		list_clear();
		pending_reqs.push_back(mk(alm_pkg::OP_GET_AT, 0, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_REMOVE_AT, 0, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_READ_SLOT, 0, 63, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_REMOVE_SLOT, 0, 5, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AFTER, 0, 0, 1));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AT, 1, 0, 2));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AT, 0, 0, 8'hff));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AT, 1, 0, 8'h00));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AT, 2, 0, 8'haa));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AT, 1, 0, 8'h55));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AFTER, 0, 0, 8'h11));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_BEFORE, 0, 2, 8'h22));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AFTER, 0, 2, 8'h33));
		pending_reqs.push_back(mk(alm_pkg::OP_GET_AT, 7, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_GET_AT, 127, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_GET_AT, 3, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_READ_SLOT, 0, 0, 0));
		pending_reqs.push_back(mk(OP_UNDEF, 0, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_REMOVE_AT, 0, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_REMOVE_AT, 4, 0, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_REMOVE_SLOT, 0, 1, 0));
		pending_reqs.push_back(mk(alm_pkg::OP_INSERT_AT, 100, 0, 0));
		foreach (pending_reqs[i]) void'(list_apply(pending_reqs[i]));
		// fill to full, then hit the full error
		for (int i = 0; i < 70; i++) begin
			r = mk(alm_pkg::OP_INSERT_AT, $urandom_range(0, count_q), 0, $urandom);
			pending_reqs.push_back(r);
			void'(list_apply(r));
		end
		r = mk(alm_pkg::OP_INSERT_AFTER, 0, pick_slot(), 0);
		pending_reqs.push_back(r);
		void'(list_apply(r));
		// random mix, drifting between nearly empty and nearly full
		n = 0;
		while (n < 330) begin
			int w;
			w = $urandom_range(0, 99);
			if (w < 10)
				r = mk(alm_pkg::OP_INSERT_AT, $urandom_range(0, count_q + 1), 0, $urandom);
			else if (w < 20) r = mk(alm_pkg::OP_INSERT_AFTER, 0, pick_slot(), $urandom);
			else if (w < 30) r = mk(alm_pkg::OP_INSERT_BEFORE, 0, pick_slot(), $urandom);
			else if (w < 42) r = mk(alm_pkg::OP_REMOVE_SLOT, 0, pick_slot(), $urandom);
			else if (w < 55)
				r = mk(alm_pkg::OP_REMOVE_AT, $urandom_range(0, count_q), 0, $urandom);
			else if (w < 75) r = mk(alm_pkg::OP_GET_AT, $urandom_range(0, count_q), 0, $urandom);
			else if (w < 90) r = mk(alm_pkg::OP_READ_SLOT, 0, pick_slot(), $urandom);
			else if (w < 93) r = mk(OP_UNDEF, $urandom, $urandom, $urandom);
			else r = mk(3'($urandom_range(0, 6)), $urandom_range(0, 127), $urandom, $urandom);
			pending_reqs.push_back(r);
			void'(list_apply(r));
			n++;
		end
		list_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			replies_due.push_back(list_apply(request_t'(s_tdata)));
			send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
		end
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (send_gap > 0 || pending_reqs.size() == 0) begin
				if (send_gap > 0) send_gap--;
				s_tvalid <= 1'b0;
				if (pending_reqs.size() == 0 && !(s_tvalid && !s_tready)) stim_done = 1;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_reqs.pop_front();
			end
		end
	end

	// monitor with random stalls and one long hold-off
	int recv_gap = 0;
	int result_count = 0;
	always @(posedge clk) begin
		reply_t got, want;
		if (m_tvalid && m_tready) begin
			got = reply_t'(m_tdata[$bits(reply_t)-1:0]);
			result_count++;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
			recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			if (result_count == 120) hold_off = 300;
		end
		if (hold_off > 0) begin
			hold_off--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	// watchdog and end of run
	int idle_cycles = 0;
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (stim_done && replies_due.size() == 0) begin
				repeat (100) @(posedge clk);
				if (errors == 0 && replies_due.size() == 0) $display("testbench OK");
				else $display("testbench NOT OK");
				$finish;
			end else if (idle_cycles >= WATCH_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

endmodule
